// ===== hdl/dmdc_pkg.sv =====
package dmdc_pkg;

    localparam int MEM_WORDS_DEF  = 1024;
    localparam int LINE_COUNT_DEF = 8;
    localparam int LINE_WORDS_DEF = 4;
    localparam int WORD_W         = 32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_STORE = 1'b1;

endpackage

// ===== hdl/direct_mapped_data_cache.sv =====
// Direct-mapped write-through, write-allocate data cache with its backing data memory.
// Command channel: an item (req_type, address, store_data) is taken at a rising edge
// with start high and busy low. Every item gives exactly one result on load_data and
// cache_hit, shown for one cycle with done high; the receiver cannot stall it.
// Config: cfg_write with cfg_data sets cache_enable; write it only while idle.
// done is registered: acceptance moves the state to LOOKUP, and done is set from that state.
// A load hit, or any access with the cache disabled, goes through LOOKUP back to IDLE;
// a load miss or a store with the cache enabled then refills the line in REFILL, with busy
// high and no new item taken, because the line refill reads the single data memory
// read port one word per cycle. A store writes memory at its accepting edge.
// Reset clears busy, done, cache_enable and all line valid bits; memory contents
// stay undefined until written. MEM_WORDS, LINE_COUNT and LINE_WORDS are powers
// of two, with LINE_WORDS not above MEM_WORDS.
module direct_mapped_data_cache #(
    parameter int MEM_WORDS  = dmdc_pkg::MEM_WORDS_DEF,
    parameter int LINE_COUNT = dmdc_pkg::LINE_COUNT_DEF,
    parameter int LINE_WORDS = dmdc_pkg::LINE_WORDS_DEF,
    localparam int ADDR_W    = $clog2(MEM_WORDS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [ADDR_W-1:0]           address,
    input  logic [dmdc_pkg::WORD_W-1:0] store_data,
    input  logic                        cfg_write,
    input  logic                        cfg_data,
    output logic                        done,
    output logic [dmdc_pkg::WORD_W-1:0] load_data,
    output logic                        cache_hit
);

    localparam int CACHE_WORDS = LINE_COUNT * LINE_WORDS;
    localparam int OFF_B       = $clog2(LINE_WORDS);
    localparam int CW_B        = $clog2(CACHE_WORDS);
    localparam int LINE_W      = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int CIDX_W      = (CW_B > 0) ? CW_B : 1;
    localparam int CNT_W       = (OFF_B > 0) ? OFF_B : 1;
    localparam int TAG_W       = (ADDR_W > CW_B) ? ADDR_W - CW_B : 1;
    localparam int WW          = dmdc_pkg::WORD_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_REFILL = 2'd2;

    logic [WW-1:0]     main_mem [MEM_WORDS];
    logic [WW-1:0]     word_mem [CACHE_WORDS];
    logic [TAG_W-1:0]  tag_mem  [LINE_COUNT];

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              enable_reg;
    logic [LINE_COUNT-1:0] valid_reg;
    logic              done_reg, done_next;
    logic [WW-1:0]     load_data_reg, load_data_next;
    logic              hit_reg, hit_next;

    logic              req_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [WW-1:0]     mem_q;
    logic [WW-1:0]     word_q;
    logic [TAG_W-1:0]  tag_q;

    logic              accept;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] rd_addr;
    logic [LINE_W-1:0] line_idx;
    logic [TAG_W-1:0]  addr_tag;
    logic [CIDX_W-1:0] fill_idx;
    logic              lookup_hit;
    logic              need_refill;
    logic              last_word;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign base      = addr_reg & ~ADDR_W'(LINE_WORDS - 1);
    assign line_idx  = LINE_W'((addr_reg / LINE_WORDS) % LINE_COUNT);
    assign addr_tag  = TAG_W'(addr_reg / CACHE_WORDS);
    assign fill_idx  = CIDX_W'((base + ADDR_W'(cnt_reg)) % CACHE_WORDS);
    assign last_word = (cnt_reg == CNT_W'(LINE_WORDS - 1));

    assign lookup_hit  = enable_reg && (req_reg == dmdc_pkg::REQ_LOAD)
                         && valid_reg[line_idx] && (tag_q == addr_tag);
    assign need_refill = enable_reg && !lookup_hit;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   rd_addr = address;
            ST_LOOKUP: rd_addr = base;
            ST_REFILL: rd_addr = base + ADDR_W'(cnt_reg) + ADDR_W'(1);
            default:   rd_addr = address;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req_type == dmdc_pkg::REQ_STORE))
        begin
            main_mem[address] <= store_data;
        end
        mem_q <= main_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_REFILL)
        begin
            word_mem[fill_idx] <= mem_q;
        end
        word_q <= word_mem[CIDX_W'(address % CACHE_WORDS)];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_REFILL) && last_word)
        begin
            tag_mem[line_idx] <= addr_tag;
        end
        tag_q <= tag_mem[LINE_W'((address / LINE_WORDS) % LINE_COUNT)];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            addr_reg <= address;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        done_next      = 1'b0;
        load_data_next = load_data_reg;
        hit_next       = hit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                done_next = 1'b1;
                hit_next  = lookup_hit;
                if (req_reg == dmdc_pkg::REQ_STORE)
                begin
                    load_data_next = '0;
                end
                else if (lookup_hit)
                begin
                    load_data_next = word_q;
                end
                else
                begin
                    load_data_next = mem_q;
                end
                cnt_next   = '0;
                state_next = need_refill ? ST_REFILL : ST_IDLE;
            end
            ST_REFILL:
            begin
                if (last_word)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            enable_reg    <= 1'b0;
            valid_reg     <= '0;
            done_reg      <= 1'b0;
            load_data_reg <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            load_data_reg <= load_data_next;
            hit_reg       <= hit_next;
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
            end
            if ((state_reg == ST_REFILL) && last_word)
            begin
                valid_reg[line_idx] <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign load_data = load_data_reg;
    assign cache_hit = hit_reg;

endmodule
